// ===== design/running_median_two_heaps_defines.svh =====
// Assertion macros used by the running-median top-level design file.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
// Checks that an antecedent implies a consequent in the same cycle.
`define RMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Checks that an antecedent implies a consequent in the next cycle.
`define RMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

// ===== design/rmh_pkg.sv =====
// Package with the constants and types of the running-median store.
package rmh_pkg;
	localparam int SampleBits = 32;
	localparam int Capacity = 1024;
	localparam int HeapDepth = (Capacity + 1) / 2;
	localparam int AddrBits = $clog2(HeapDepth);
	localparam int SizeBits = $clog2(HeapDepth + 1);
	localparam int CountBits = 11;

	typedef logic signed [SampleBits-1:0] sample_t;
	typedef logic [AddrBits-1:0] addr_t;
	typedef logic [SizeBits-1:0] size_t;

	// Operation requested of one heap unit.
	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP
	} heap_op_t;

	// Command from the sequencer to a heap unit.
	typedef struct packed {
		logic     start;
		heap_op_t op;
		sample_t  value;
	} heap_cmd_t;

	// Status from a heap unit to the sequencer.
	typedef struct packed {
		logic    busy;
		logic    done;
		sample_t top;
		sample_t popped;
		size_t   size;
	} heap_stat_t;
endpackage

// ===== design/rmh_heap.sv =====
// One binary heap in a memory, with iterative sift-up push and sift-down pop.
module rmh_heap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               is_max,
	input  rmh_pkg::heap_cmd_t cmd,
	output rmh_pkg::heap_stat_t stat
);
	import rmh_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_UP_RD, S_UP_WAIT, S_UP_CMP,
		S_DN_RD, S_DN_RD2, S_DN_WAIT, S_DN_CMP, S_DN_CMP2, S_DONE
	} state_t;

	state_t state_q;
	sample_t mem [HeapDepth];
	sample_t rdata_q, top_q, val_q, popped_q, best_val_q;
	addr_t   idx_q, best_q, rd_addr, wr_addr;
	size_t   size_q;
	sample_t wr_data;
	logic    wr_en;
	logic    [AddrBits:0] lchild, rchild;

	// Heap order compare: true when a belongs nearer the top than b.
	function automatic logic above(input sample_t a, input sample_t b, input logic mx);
		above = mx ? (a > b) : (a < b);
	endfunction

	assign lchild = {idx_q, 1'b1};
	assign rchild = {idx_q, 1'b1} + 1'b1;

	// Memory with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	// Read address follows the sequencer state. While idle the last entry is
	// fetched so that a pop can start from it.
	always_comb begin
		rd_addr = '0;
		case (state_q) inside
			S_IDLE: rd_addr = addr_t'(size_q - 1'b1);
			S_UP_RD, S_UP_WAIT: rd_addr = addr_t'((idx_q - 1'b1) >> 1);
			S_DN_RD: rd_addr = lchild[AddrBits-1:0];
			S_DN_RD2: rd_addr = rchild[AddrBits-1:0];
			default: rd_addr = '0;
		endcase
	end

	// Writes happen in the clocked block; combinational mirror of them here.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = val_q;
		unique case (state_q)
			S_UP_CMP: begin
				if (idx_q != '0 && above(val_q, rdata_q, is_max)) begin
					wr_en = 1'b1;
					wr_data = rdata_q;
				end else begin
					wr_en = 1'b1;
				end
			end
			S_DN_CMP2: begin
				wr_en = 1'b1;
				if (best_q != idx_q) wr_data = best_val_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	// Sequencer: walks the heap one memory level at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_q <= '0;
			idx_q <= '0;
			top_q <= '0;
			val_q <= '0;
			popped_q <= '0;
			best_q <= '0;
			best_val_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						if (cmd.op == OP_PUSH) begin
							idx_q <= addr_t'(size_q);
							val_q <= cmd.value;
							size_q <= size_q + 1'b1;
							if (size_q == '0) begin
								top_q <= cmd.value;
								state_q <= S_UP_CMP;
							end else begin
								state_q <= S_UP_RD;
							end
						end else begin
							popped_q <= top_q;
							size_q <= size_q - 1'b1;
							idx_q <= addr_t'(size_q - 1'b1);
							state_q <= S_DN_WAIT;
						end
					end
				end
				S_UP_RD: state_q <= S_UP_WAIT;
				S_UP_WAIT: state_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (idx_q != '0 && above(val_q, rdata_q, is_max)) begin
						idx_q <= addr_t'((idx_q - 1'b1) >> 1);
						state_q <= S_UP_RD;
					end else begin
						if (idx_q == '0) top_q <= val_q;
						state_q <= S_DONE;
					end
				end
				S_DN_WAIT: begin
					// The last entry, read while idle, fills the hole at the root.
					state_q <= S_DN_RD;
					idx_q <= '0;
					val_q <= rdata_q;
				end
				S_DN_RD: begin
					state_q <= S_DN_RD2;
					best_q <= idx_q;
					best_val_q <= val_q;
				end
				S_DN_RD2: begin
					state_q <= S_DN_CMP;
					if (lchild < (AddrBits+1)'(size_q) &&
						above(rdata_q, val_q, is_max)) begin
						best_q <= lchild[AddrBits-1:0];
						best_val_q <= rdata_q;
					end
				end
				S_DN_CMP: begin
					state_q <= S_DN_CMP2;
					if (rchild < (AddrBits+1)'(size_q) &&
						above(rdata_q, best_val_q, is_max)) begin
						best_q <= rchild[AddrBits-1:0];
						best_val_q <= rdata_q;
					end
				end
				S_DN_CMP2: begin
					if (idx_q == '0)
						top_q <= (best_q != idx_q) ? best_val_q : val_q;
					if (best_q != idx_q) begin
						idx_q <= best_q;
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign stat.top = top_q;
	assign stat.popped = popped_q;
	assign stat.size = size_q;
endmodule

// ===== design/running_median_two_heaps.sv =====
// Running median over signed samples kept in a max-heap and a min-heap in two memories.
// Each transaction on s_axis inserts one sample unless the store is full and gives one
// transaction on m_axis with twice the median, the count held and a drop flag. The block
// takes one sample at a time and is not ready again until its result has been taken.
// A push walks each heap level through a read, a wait and a compare state, and a pop
// through reading the left and right child and comparing each, as each heap memory has a
// single registered read port. Each heap holds up to 512 entries. No clearing pass follows reset.
`include "running_median_two_heaps_defines.svh"
module running_median_two_heaps (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata    // [32:0] median_twice, [43:33] held_count, [44] dropped
);
	import rmh_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DECIDE, S_STEP1, S_STEP2, S_WAIT2, S_STEP3, S_WAIT3, S_OUT
	} state_t;

	state_t state_q;
	heap_cmd_t lo_cmd, up_cmd;
	heap_stat_t lo_st, up_st;
	sample_t x_q, mv_q;
	logic dropped_q, move_lo_q, move_up_q, to_lo_q;
	logic [32:0] med;
	logic [CountBits-1:0] held;

	rmh_heap u_lo (.clk(clk), .arst_n(arst_n), .is_max(1'b1), .cmd(lo_cmd), .stat(lo_st));
	rmh_heap u_up (.clk(clk), .arst_n(arst_n), .is_max(1'b0), .cmd(up_cmd), .stat(up_st));

	assign held = CountBits'(lo_st.size) + CountBits'(up_st.size);

	// Median from the two tops.
	always_comb begin
		if (lo_st.size == '0 && up_st.size == '0) med = '0;
		else if (lo_st.size == up_st.size) med = 33'(lo_st.top) + 33'(up_st.top);
		else if (lo_st.size > up_st.size) med = {lo_st.top, 1'b0};
		else med = {up_st.top, 1'b0};
	end

	// Heap commands issued by the sequencer, each for exactly one cycle.
	always_comb begin
		lo_cmd = '{start: 1'b0, op: OP_PUSH, value: x_q};
		up_cmd = '{start: 1'b0, op: OP_PUSH, value: x_q};
		case (state_q)
			S_STEP1: begin
				if (move_lo_q) lo_cmd = '{start: 1'b1, op: OP_POP, value: x_q};
				else if (move_up_q) up_cmd = '{start: 1'b1, op: OP_POP, value: x_q};
			end
			S_STEP2: begin
				if (move_lo_q) up_cmd = '{start: 1'b1, op: OP_PUSH, value: lo_st.popped};
				else if (move_up_q) lo_cmd = '{start: 1'b1, op: OP_PUSH, value: up_st.popped};
			end
			S_STEP3: begin
				if (to_lo_q) lo_cmd.start = 1'b1;
				else up_cmd.start = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			move_lo_q <= 1'b0;
			move_up_q <= 1'b0;
			x_q <= '0;
			dropped_q <= 1'b0;
			to_lo_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid) begin
					x_q <= s_axis_tdata;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					move_lo_q <= 1'b0;
					move_up_q <= 1'b0;
					dropped_q <= 1'b0;
					if (held >= CountBits'(Capacity)) begin
						dropped_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_STEP1;
						if (lo_st.size == '0) to_lo_q <= 1'b1;
						else if (lo_st.size == up_st.size)
							to_lo_q <= !(x_q > up_st.top) || (x_q < lo_st.top);
						else if (lo_st.size > up_st.size) begin
							to_lo_q <= x_q < lo_st.top;
							move_lo_q <= x_q < lo_st.top;
						end else begin
							to_lo_q <= !(x_q > up_st.top);
							move_up_q <= x_q > up_st.top;
						end
					end
				end
				S_STEP1: state_q <= (move_lo_q || move_up_q) ? S_STEP2 : S_STEP3;
				S_STEP2: state_q <= S_WAIT2;
				S_WAIT2: if (!lo_st.busy && !up_st.busy) state_q <= S_STEP3;
				S_STEP3: state_q <= S_WAIT3;
				S_WAIT3: if (!lo_st.busy && !up_st.busy) state_q <= S_OUT;
				S_OUT: begin
					if (!lo_st.busy && !up_st.busy && !m_axis_tvalid) begin
						m_axis_tdata <= {3'b0, dropped_q, held, med};
						m_axis_tvalid <= 1'b1;
					end
					if (m_axis_tvalid && m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);

	`RMH_ASSERT_IMP(a_no_accept_busy, clk, arst_n, s_axis_tready, !lo_st.busy && !up_st.busy)
	`RMH_ASSERT_IMP(a_sizes_close, clk, arst_n, s_axis_tready,
		(lo_st.size == up_st.size) || (lo_st.size == up_st.size + 1'b1) ||
		(up_st.size == lo_st.size + 1'b1))
	`RMH_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, s_axis_tvalid && s_axis_tready,
		!s_axis_tready)
endmodule
